// ----- hw/rtl/utt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_pkg: shared types and constants of the UTF-16 to UTF-8 transcoder
// Command format passed from the classifier to the byte emitter, and the
// code unit ranges used to tell surrogates apart.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int unsigned UNIT_W = 16;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned BYTE_W = 8;

    localparam logic [UNIT_W-1:0] SURR_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] SURR_LAST  = 16'hDFFF;
    localparam logic [UNIT_W-1:0] UNIT_MAX   = 16'hFFFF;

    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;
    localparam logic [CP_W-1:0]   ONE_LIMIT  = 21'h80;
    localparam logic [CP_W-1:0]   TWO_LIMIT  = 21'h800;

    // UTF-8 sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

    // One queued command: a code point of len bytes, then an optional terminator
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             term;
    } t_cmd;

endpackage

// ----- hw/rtl/utt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_front: code unit classifier
// Accepts UTF-16 code units, pairs surrogates, tracks the string limit and
// turns each unit into at most one command for the byte emitter.
// ----------------------------------------------------------------------------
module utt_front
    import utt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic [UNIT_W-1:0] i_max_units,
    output logic              o_cmd_push,
    output t_cmd              o_cmd
);

    logic              r_held_valid, n_held_valid;
    logic [9:0]        r_held_bits, n_held_bits;
    logic [UNIT_W-1:0] r_count, n_count;
    logic              r_skip, n_skip;

    logic [UNIT_W-1:0] cnt_inc;
    logic              at_limit;
    logic              is_surr;
    logic              is_high;
    logic              is_low;
    logic [CP_W-1:0]   pair_cp;
    logic [CP_W-1:0]   bmp_cp;
    t_cmd              cmd;

    assign cnt_inc  = (r_count == UNIT_MAX) ? r_count : r_count + 16'd1;
    assign at_limit = (i_max_units != '0) && (cnt_inc >= i_max_units);
    assign is_surr  = (i_code_unit >= SURR_FIRST) && (i_code_unit <= SURR_LAST);
    assign is_high  = is_surr && (i_code_unit <= HIGH_LAST);
    assign is_low   = is_surr && (i_code_unit >= LOW_FIRST);
    assign pair_cp  = SUPP_BASE + {1'b0, r_held_bits, i_code_unit[9:0]};
    assign bmp_cp   = {5'd0, i_code_unit};

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        n_count      = r_count;
        n_skip       = r_skip;
        cmd.cp       = bmp_cp;
        cmd.len      = LEN_NONE;
        cmd.term     = 1'b0;
        if (r_skip) begin
            // drop everything until the zero unit that ends the string
            if (i_code_unit == '0) begin
                n_skip = 1'b0;
            end
        end else if (i_code_unit == '0) begin
            n_held_valid = 1'b0;
            n_held_bits  = '0;
            n_count      = '0;
            cmd.term     = 1'b1;
        end else begin
            n_count      = cnt_inc;
            n_held_valid = 1'b0;
            n_held_bits  = '0;
            if (r_held_valid && is_low) begin
                cmd.cp  = pair_cp;
                cmd.len = LEN_FOUR;
            end else if (!is_surr) begin
                if (bmp_cp < ONE_LIMIT) begin
                    cmd.len = LEN_ONE;
                end else if (bmp_cp < TWO_LIMIT) begin
                    cmd.len = LEN_TWO;
                end else begin
                    cmd.len = LEN_THREE;
                end
            end else if (is_high && !at_limit) begin
                n_held_valid = 1'b1;
                n_held_bits  = i_code_unit[9:0];
            end
            if (at_limit) begin
                n_held_valid = 1'b0;
                n_held_bits  = '0;
                n_count      = '0;
                n_skip       = 1'b1;
                cmd.term     = 1'b1;
            end
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && ((cmd.len != LEN_NONE) || cmd.term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
            r_count      <= '0;
            r_skip       <= 1'b0;
        end else if (i_accept) begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
            r_count      <= n_count;
            r_skip       <= n_skip;
        end
    end

endmodule

// ----- hw/rtl/utt_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_fifo: command queue
// Small queue between classifier and emitter; head entry is shown directly.
// ----------------------------------------------------------------------------
module utt_fifo
    import utt_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/utt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_back: UTF-8 byte emitter
// Walks commands one byte per cycle unless stalled into the output register.
// ----------------------------------------------------------------------------
module utt_back
    import utt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last
);

    t_cmd              r_cmd;
    logic              r_busy;
    logic [LEN_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    t_cmd              src;
    logic [LEN_W-1:0]  idx;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  pos;
    logic              emit;
    logic              done;
    logic              is_term;
    logic [BYTE_W-1:0] byte_val;

    assign src     = r_busy ? r_cmd : i_cmd;
    assign idx     = r_busy ? r_idx : '0;
    assign total   = src.len + {2'd0, src.term};
    assign emit    = (r_busy || !i_cmd_empty) && (!r_out_valid || i_pop);
    assign done    = (idx + 3'd1) == total;
    assign is_term = (idx == src.len);
    assign pos     = src.len - idx - 3'd1;

    always_comb begin
        byte_val = TERM_BYTE;
        if (!is_term) begin
            if (idx == '0) begin
                case (src.len)
                    LEN_ONE:   byte_val = {1'b0, src.cp[6:0]};
                    LEN_TWO:   byte_val = {3'b110, src.cp[10:6]};
                    LEN_THREE: byte_val = {4'b1110, src.cp[15:12]};
                    LEN_FOUR:  byte_val = {5'b11110, src.cp[20:18]};
                    default:   byte_val = TERM_BYTE;
                endcase
            end else begin
                case (pos)
                    3'd0:    byte_val = {2'b10, src.cp[5:0]};
                    3'd1:    byte_val = {2'b10, src.cp[11:6]};
                    3'd2:    byte_val = {2'b10, src.cp[17:12]};
                    default: byte_val = TERM_BYTE;
                endcase
            end
        end
    end

    assign o_cmd_pop = emit && !r_busy;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_val;
            r_out_last <= is_term;
            if (!r_busy) begin
                r_cmd <= i_cmd;
            end
            r_idx <= idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy      <= !done;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ----- hw/rtl/utf16_to_utf8_transcoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit: UTF-16 code units in, UTF-8 bytes out
// Path: a code unit accepted into the front goes through the command queue and
//   then the output register before its first byte shows on the byte ports.
// Throughput: one code unit per cycle in while the command queue has room;
//   one byte per cycle out while bytes are popped; a unit makes 0 to 5 bytes.
// Reset (synchronous, active low) clears the queue, the held surrogate, the
//   unit count, the skip mode, the output slot and max_units.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit
    import utt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // code unit side
    input  logic              push,
    output logic              full,
    input  logic [UNIT_W-1:0] i_code_unit,
    // byte side
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Register file: max_units is the only register, at byte address 0.
    // paddr holds just the byte offset, so every transaction hits it.
    logic [UNIT_W-1:0] r_max_units;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[1:0] <= 2'd3);
    assign prdata    = {16'd0, r_max_units};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= '0;
        end else if (cfg_write) begin
            r_max_units <= pwdata[UNIT_W-1:0];
        end
    end

    // Front: accept a unit whenever the command queue can take its command.
    // A unit always makes at most one command, so queue space is the only stall.
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic cmd_push;
    logic accept;
    t_cmd front_cmd;
    t_cmd head_cmd;

    assign full   = q_full;
    assign accept = push && !q_full;

    utt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_unit (i_code_unit),
        .i_max_units (r_max_units),
        .o_cmd_push  (cmd_push),
        .o_cmd       (front_cmd)
    );

    // Queue decouples unit intake from byte emission
    utt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: expand each command into bytes; the output register holds a
    // byte while the consumer stalls, and refills in the cycle it is taken.
    utt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// ----- hw/rtl/utt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_checker: port-level checks of the transcoder
// Watches the byte channel for well-formed UTF-8 and stable stalled bytes.
// ----------------------------------------------------------------------------
module utt_checker
    import utt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_last
);

    // Output slot is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("byte channel not empty after reset");

    // Terminator transaction carries a zero byte
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_out_byte == TERM_BYTE))
        else $error("terminator byte is not zero");

    // Never show overlong or out-of-range lead bytes
    a_legal_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_byte != 8'hC0) && (o_out_byte != 8'hC1)
                   && (o_out_byte < 8'hF8))
        else $error("illegal UTF-8 byte");

    // A four-byte lead is followed at once by a continuation byte
    a_lead_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && (o_out_byte[7:3] == 5'b11110))
        |=> (!empty && (o_out_byte[7:6] == 2'b10)))
        else $error("continuation byte missing after lead byte");

    // Hold a stalled byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("stalled byte changed");

endmodule

bind utf16_to_utf8_transcoder_unit utt_checker u_utt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);
